/* rtl/sda_pkg.sv */
// ----------------------------------------------------------------------------
// sda_pkg
// Shared types and constants for the SPH density accumulator: sequencer
// steps, register indexes, reset values and the command/status structs.
// ----------------------------------------------------------------------------
package sda_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;
   localparam int RADIUS_W    = 40;
   localparam int FACTOR_W    = 32;
   localparam int DENSITY_W   = 32;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int UNIT_W      = 31;
   localparam int RATIO_LO_W  = 36;
   localparam int RATIO_W     = 45;

   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET     = 40'd171798692;
   localparam logic [FACTOR_W-1:0] INV_RADIUS_SQ_RESET = 32'd1677721600;
   localparam logic [FACTOR_W-1:0] KERNEL_COEF_RESET   = 32'd128356352;
   localparam logic [UNIT_W-1:0]   RATIO_ONE           = 31'h4000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RADIUS_SQ     = 2'd0,
      REG_INV_RADIUS_SQ = 2'd1,
      REG_KERNEL_COEF   = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_RAT_LO,
      ST_RAT_HI,
      ST_RAT_SUM,
      ST_CUBE_2,
      ST_CUBE_3,
      ST_SCALE,
      ST_ACCUM
   } step_type;

   typedef struct packed {
      step_type step;
      logic     capture;
      logic     accum;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic out_busy;
   } dp_status_type;

endpackage

/* rtl/sda_ctrl.sv */
// ----------------------------------------------------------------------------
// sda_ctrl
// Sequencer for one neighbor pair: squares, ratio, cube, scale, accumulate.
// ----------------------------------------------------------------------------
module sda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output sda_pkg::dp_cmd_type   cmd,
   input  sda_pkg::dp_status_type status
);
   import sda_pkg::*;

   step_type state_ff;
   step_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.step    = state_ff;
      cmd.capture = 1'b0;
      cmd.accum   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SQ_X;
            end
         end
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_SQ_Z;
         ST_SQ_Z:    state_in = ST_SQ_SUM;
         ST_SQ_SUM:  state_in = ST_RAT_LO;
         ST_RAT_LO:  state_in = ST_RAT_HI;
         ST_RAT_HI:  state_in = ST_RAT_SUM;
         ST_RAT_SUM: state_in = ST_CUBE_2;
         ST_CUBE_2:  state_in = ST_CUBE_3;
         ST_CUBE_3:  state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_ACCUM;
         ST_ACCUM: begin
            // hold a final pair while a finished word still waits in the output register
            if (!(status.last && status.out_busy)) begin
               cmd.accum = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/sda_datapath.sv */
// ----------------------------------------------------------------------------
// sda_datapath
// Shared 32x32 multiplier with product register, squared distance, kernel
// ratio and cube, saturating density sum, output register and settings.
// ----------------------------------------------------------------------------
module sda_datapath #(
   parameter int OFFSET_WIDTH = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sda_pkg::dp_cmd_type                cmd,
   output sda_pkg::dp_status_type             status,
   input  logic [OFFSET_WIDTH-1:0]            offset_x,
   input  logic [OFFSET_WIDTH-1:0]            offset_y,
   input  logic [OFFSET_WIDTH-1:0]            offset_z,
   input  logic                               last_neighbor,
   input  logic                               csr_we,
   input  logic [sda_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sda_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sda_pkg::DENSITY_W-1:0]      rsp_density,
   output logic                               rsp_saturated
);
   import sda_pkg::*;

   localparam int D2W  = 2 * OFFSET_WIDTH;
   localparam int EXTW = (D2W > RADIUS_W) ? D2W : RADIUS_W;

   function automatic logic [OFFSET_WIDTH-1:0] magnitude(input logic [OFFSET_WIDTH-1:0] v);
      logic [OFFSET_WIDTH-1:0] neg;
      neg = (~v) + OFFSET_WIDTH'(1);
      return v[OFFSET_WIDTH-1] ? neg : v;
   endfunction

   // settings
   logic [RADIUS_W-1:0]   radius_sq_ff;
   logic [FACTOR_W-1:0]   inv_radius_sq_ff;
   logic [FACTOR_W-1:0]   kernel_coef_ff;

   // working registers
   logic [OFFSET_WIDTH-1:0] ax_ff, ay_ff, az_ff;
   logic                    last_ff;
   logic [D2W-1:0]          d2_ff;
   logic                    far_ff;
   logic [RATIO_LO_W-1:0]   ratio_lo_ff;
   logic [UNIT_W-1:0]       unit_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [DENSITY_W-1:0]    sum_ff;
   logic                    overflow_ff;
   logic                    rsp_valid_ff;
   logic [DENSITY_W-1:0]    rsp_density_ff;
   logic                    rsp_sat_ff;

   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]    prod_in;
   logic [EXTW-1:0]      d2_ext;
   logic [RATIO_W-1:0]   ratio;
   logic [UNIT_W-1:0]    unit_in;
   logic [DENSITY_W-1:0] term;
   logic [DENSITY_W:0]   sum_wide;
   logic [DENSITY_W-1:0] sum_clamped;
   logic                 overflow_in;

   assign d2_ext = EXTW'(d2_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         ST_SQ_X: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(ax_ff);
         end
         ST_SQ_Y: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(ay_ff);
         end
         ST_SQ_Z: begin
            mul_a = MUL_W'(az_ff);
            mul_b = MUL_W'(az_ff);
         end
         ST_RAT_LO: begin
            mul_a = d2_ext[31:0];
            mul_b = inv_radius_sq_ff;
         end
         ST_RAT_HI: begin
            mul_a = MUL_W'(d2_ext[39:32]);
            mul_b = inv_radius_sq_ff;
         end
         ST_CUBE_2: begin
            mul_a = MUL_W'(unit_ff);
            mul_b = MUL_W'(unit_ff);
         end
         ST_CUBE_3: begin
            mul_a = MUL_W'(prod_ff[60:30]);
            mul_b = MUL_W'(unit_ff);
         end
         ST_SCALE: begin
            mul_a = kernel_coef_ff;
            mul_b = MUL_W'(prod_ff[60:30]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // ratio = (d2 * inv) >> 28 from the low and high partial products
   assign ratio   = {1'b0, prod_ff[39:0], 4'b0000} + RATIO_W'(ratio_lo_ff);
   assign unit_in = (ratio > RATIO_W'(RATIO_ONE)) ? '0 : (RATIO_ONE - ratio[UNIT_W-1:0]);

   assign term        = far_ff ? '0 : prod_ff[61:30];
   assign sum_wide    = {1'b0, sum_ff} + {1'b0, term};
   assign sum_clamped = sum_wide[DENSITY_W] ? '1 : sum_wide[DENSITY_W-1:0];
   assign overflow_in = overflow_ff | sum_wide[DENSITY_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff     <= RADIUS_SQ_RESET;
         inv_radius_sq_ff <= INV_RADIUS_SQ_RESET;
         kernel_coef_ff   <= KERNEL_COEF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_RADIUS_SQ:     radius_sq_ff     <= csr_wdata[RADIUS_W-1:0];
            REG_INV_RADIUS_SQ: inv_radius_sq_ff <= csr_wdata[FACTOR_W-1:0];
            REG_KERNEL_COEF:   kernel_coef_ff   <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff   <= magnitude(offset_x);
         ay_ff   <= magnitude(offset_y);
         az_ff   <= magnitude(offset_z);
         last_ff <= last_neighbor;
      end
      // keep the scaled term while the accumulate step waits
      if (cmd.step != ST_ACCUM) begin
         prod_ff <= prod_in;
      end
      case (cmd.step)
         ST_SQ_Y:             d2_ff <= prod_ff[D2W-1:0];
         ST_SQ_Z, ST_SQ_SUM:  d2_ff <= d2_ff + prod_ff[D2W-1:0];
         ST_RAT_LO:           far_ff <= d2_ext > EXTW'(radius_sq_ff);
         ST_RAT_HI:           ratio_lo_ff <= prod_ff[63:28];
         ST_RAT_SUM:          unit_ff <= unit_in;
         default: ;
      endcase
      if (cmd.accum && last_ff) begin
         rsp_density_ff <= sum_clamped;
         rsp_sat_ff     <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            if (last_ff) begin
               sum_ff      <= '0;
               overflow_ff <= 1'b0;
            end else begin
               sum_ff      <= sum_clamped;
               overflow_ff <= overflow_in;
            end
         end
         if (cmd.accum && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_density   = rsp_density_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

/* rtl/sph_density_accumulator.sv */
// ----------------------------------------------------------------------------
// sph_density_accumulator
// Poly6 kernel density sum over a stream of particle/neighbor displacements.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per neighbor pair, the three signed displacements
//   in tdata and the particle's final pair marked by tlast.
//   rsp channel: one word per particle, sent for each pair with tlast set:
//   the saturated density in tdata and the saturation flag in tuser.
//   csr port: write radius squared, its inverse and the mass/kernel factor
//   while no pair is in flight; a write to an unknown index is dropped.
// Timing:
//   A pair is accepted, then runs 11 sequencer steps; the multiply steps share
//   one 32x32 multiplier (three squares, two ratio partial products, two
//   cube products, one scale), and the last step adds into the running sum.
//   The final pair's accumulate step loads the density word into rsp.
// Reset:
//   Clears the sum, the saturation flag and the output valid flag and loads
//   the default kernel settings. req_tready is high right after reset.
// Stall:
//   The output register holds a word until taken; pairs keep flowing until
//   another final pair completes, which waits in its last step.
// ----------------------------------------------------------------------------
module sph_density_accumulator #(
   parameter int OFFSET_WIDTH = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // offset_x, offset_y, offset_z, zero padding
   input  logic [((3*OFFSET_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // density
   output logic [sda_pkg::DENSITY_W-1:0]          rsp_tdata,
   // saturated
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [sda_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sda_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import sda_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sda_datapath #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .offset_x      (req_tdata[OFFSET_WIDTH-1:0]),
      .offset_y      (req_tdata[2*OFFSET_WIDTH-1:OFFSET_WIDTH]),
      .offset_z      (req_tdata[3*OFFSET_WIDTH-1:2*OFFSET_WIDTH]),
      .last_neighbor (req_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_density   (rsp_tdata),
      .rsp_saturated (rsp_tuser)
   );

endmodule

/* rtl/sda_checker.sv */
// ----------------------------------------------------------------------------
// sda_checker
// Port-level checks for the density accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module sda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again while a pair is in flight");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp word appeared without a pair in flight");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'hFFFF_FFFF)
      else $error("saturated density below full scale");

endmodule

bind sph_density_accumulator sda_checker u_sda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
